// ----- src/cqs_pkg.sv -----
package cqs_pkg;

   // request types
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_CLASS  = 2'd2;
   localparam logic [1:0] REQ_SIMILAR = 2'd3;

   // job classes
   localparam logic [1:0] CLS_NONE       = 2'd0;
   localparam logic [1:0] CLS_UNCLASS    = 2'd1;
   localparam logic [1:0] CLS_SECRET     = 2'd2;
   localparam logic [1:0] CLS_TOP_SECRET = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_BAD_CLASS = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // command from the request decoder to the scan/shift engine
   typedef struct packed {
      logic       start;
      logic       append;
      logic       any;
      logic [1:0] cls;
   } cqs_cmd_type;

   // engine status back to the decoder
   typedef struct packed {
      logic done;
      logic hit;
      logic head_we;
   } cqs_stat_type;

endpackage

// ----- src/cqs_store.sv -----
module cqs_store import cqs_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int DW    = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/cqs_engine.sv -----
module cqs_engine import cqs_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int JOB_ID_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cqs_cmd_type                        cmd,
   input  logic [JOB_ID_BITS-1:0]             app_id,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   occ,
   output cqs_stat_type                       stat,
   output logic [JOB_ID_BITS-1:0]             ent_id,
   output logic [1:0]                         ent_cls
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int PW = $clog2(QUEUE_DEPTH + 2);
   localparam int DW = JOB_ID_BITS + 2;

   localparam logic [1:0] E_IDLE  = 2'd0;
   localparam logic [1:0] E_SCAN  = 2'd1;
   localparam logic [1:0] E_SHIFT = 2'd2;

   logic [1:0]    st_ff, st_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [1:0]    cls_ff, cls_in;
   logic          any_ff, any_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [DW-1:0] rd_data;
   logic          issue;
   logic [PW-1:0] wa;

   // entry store: {job id, class}
   cqs_store #(
      .DEPTH (QUEUE_DEPTH),
      .DW    (DW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign ent_id  = rd_data[DW-1:2];
   assign ent_cls = rd_data[1:0];

   // valid read data (pend_ff set) belongs to address ptr_ff - 1
   assign issue = (ptr_ff < PW'(occ));
   assign wa    = ptr_ff - PW'(2);

   // sequencer: appends write at the tail; removals scan for the oldest match, then close the gap
   always_comb begin
      st_in   = st_ff;
      ptr_in  = ptr_ff;
      pend_in = pend_ff;
      cls_in  = cls_ff;
      any_in  = any_ff;
      wr_en   = 1'b0;
      wr_addr = occ[AW-1:0];
      wr_data = {app_id, cmd.cls};
      stat    = '0;
      case (st_ff)
         E_IDLE: begin
            if (cmd.start) begin
               if (cmd.append) begin
                  wr_en = 1'b1;
               end else begin
                  st_in   = E_SCAN;
                  ptr_in  = '0;
                  pend_in = 1'b0;
                  cls_in  = cmd.cls;
                  any_in  = cmd.any;
               end
            end
         end
         E_SCAN: begin
            ptr_in  = ptr_ff + PW'(1);
            pend_in = issue;
            if (pend_ff && (any_ff || ent_cls == cls_ff)) begin
               stat.hit = 1'b1;
               st_in    = E_SHIFT;
            end
         end
         E_SHIFT: begin
            // move entry at ptr-1 down to ptr-2
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa[AW-1:0];
               wr_data = rd_data;
               if (wa == '0) begin
                  stat.head_we = 1'b1;
               end
            end
            ptr_in  = ptr_ff + PW'(1);
            pend_in = issue;
            if (!pend_ff || !issue) begin
               stat.done = 1'b1;
               st_in     = E_IDLE;
               pend_in   = 1'b0;
            end
         end
         default: begin
            st_in   = E_IDLE;
            pend_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= E_IDLE;
         pend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         pend_ff <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      cls_ff <= cls_in;
      any_ff <= any_in;
   end

endmodule

// ----- src/class_selective_job_queue_unit.sv -----
// channel  | beat direction | handshake           | payload
// req_     | in             | req_valid/req_ready | req_type, req_job_id, req_job_class
// rsp_     | out            | rsp_valid/rsp_ready | status, removed entry, counts, head
//
// append and rejected requests: result in the cycle after the beat is taken
// removals: one entry per cycle through the single store read port,
//   scanning then shifting the tail down
// one request at a time: req_ready is high only when no request or result is pending
// synchronous active-high reset empties the queue; store contents stay as they were
// a stalled result holds all rsp_ fields until taken
module class_selective_job_queue_unit import cqs_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int JOB_ID_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [JOB_ID_BITS-1:0]             req_job_id,
   input  logic [1:0]                         req_job_class,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [JOB_ID_BITS-1:0]             rsp_removed_job_id,
   output logic [1:0]                         rsp_removed_class,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_unclassified_count,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_secret_count,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_top_secret_count,
   output logic [1:0]                         rsp_head_class,
   output logic [JOB_ID_BITS-1:0]             rsp_head_job_id
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BUSY = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          occ_ff, occ_in;
   logic [CW-1:0]          un_cnt_ff, un_cnt_in;
   logic [CW-1:0]          se_cnt_ff, se_cnt_in;
   logic [CW-1:0]          ts_cnt_ff, ts_cnt_in;
   logic [JOB_ID_BITS-1:0] head_id_ff, head_id_in;
   logic [1:0]             head_cls_ff, head_cls_in;
   logic [1:0]             status_ff, status_in;
   logic [JOB_ID_BITS-1:0] rm_id_ff, rm_id_in;
   logic [1:0]             rm_cls_ff, rm_cls_in;

   cqs_cmd_type            cmd;
   cqs_stat_type           stat;
   logic [JOB_ID_BITS-1:0] ent_id;
   logic [1:0]             ent_cls;
   logic                   acc;
   logic [1:0]             tgt;
   logic [CW-1:0]          tgt_cnt;

   cqs_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .JOB_ID_BITS (JOB_ID_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .app_id  (req_job_id),
      .occ     (occ_ff),
      .stat    (stat),
      .ent_id  (ent_id),
      .ent_cls (ent_cls)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_RESP);

   // class to remove: similar-class picks the busier secured class
   always_comb begin
      tgt = req_job_class;
      if (req_type == REQ_SIMILAR && req_job_class != CLS_UNCLASS) begin
         if (se_cnt_ff > ts_cnt_ff) begin
            tgt = CLS_SECRET;
         end else if (se_cnt_ff < ts_cnt_ff) begin
            tgt = CLS_TOP_SECRET;
         end
      end
      case (tgt)
         CLS_UNCLASS:    tgt_cnt = un_cnt_ff;
         CLS_SECRET:     tgt_cnt = se_cnt_ff;
         CLS_TOP_SECRET: tgt_cnt = ts_cnt_ff;
         default:        tgt_cnt = '0;
      endcase
   end

   // request decode, counters and result bookkeeping
   always_comb begin
      state_in    = state_ff;
      occ_in      = occ_ff;
      un_cnt_in   = un_cnt_ff;
      se_cnt_in   = se_cnt_ff;
      ts_cnt_in   = ts_cnt_ff;
      head_id_in  = head_id_ff;
      head_cls_in = head_cls_ff;
      status_in   = status_ff;
      rm_id_in    = rm_id_ff;
      rm_cls_in   = rm_cls_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               rm_id_in  = '0;
               rm_cls_in = CLS_NONE;
               status_in = ST_OK;
               state_in  = S_RESP;
               case (req_type)
                  REQ_APPEND: begin
                     if (req_job_class == CLS_NONE) begin
                        status_in = ST_BAD_CLASS;
                     end else if (occ_ff == CW'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.start  = 1'b1;
                        cmd.append = 1'b1;
                        cmd.cls    = req_job_class;
                        occ_in     = occ_ff + CW'(1);
                        if (occ_ff == '0) begin
                           head_id_in  = req_job_id;
                           head_cls_in = req_job_class;
                        end
                        case (req_job_class)
                           CLS_UNCLASS: un_cnt_in = un_cnt_ff + CW'(1);
                           CLS_SECRET:  se_cnt_in = se_cnt_ff + CW'(1);
                           default:     ts_cnt_in = ts_cnt_ff + CW'(1);
                        endcase
                     end
                  end
                  REQ_POP: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cmd.start = 1'b1;
                        cmd.any   = 1'b1;
                        state_in  = S_BUSY;
                     end
                  end
                  default: begin
                     if (req_job_class == CLS_NONE) begin
                        status_in = ST_BAD_CLASS;
                     end else if (tgt_cnt == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cmd.start = 1'b1;
                        cmd.cls   = tgt;
                        state_in  = S_BUSY;
                     end
                  end
               endcase
            end
         end
         S_BUSY: begin
            if (stat.hit) begin
               rm_id_in  = ent_id;
               rm_cls_in = ent_cls;
            end
            if (stat.done) begin
               occ_in   = occ_ff - CW'(1);
               state_in = S_RESP;
               case (rm_cls_ff)
                  CLS_UNCLASS:    un_cnt_in = un_cnt_ff - CW'(1);
                  CLS_SECRET:     se_cnt_in = se_cnt_ff - CW'(1);
                  CLS_TOP_SECRET: ts_cnt_in = ts_cnt_ff - CW'(1);
                  default:        un_cnt_in = un_cnt_ff;
               endcase
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // new head written by the shift
      if (stat.head_we) begin
         head_id_in  = ent_id;
         head_cls_in = ent_cls;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         occ_ff    <= '0;
         un_cnt_ff <= '0;
         se_cnt_ff <= '0;
         ts_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         un_cnt_ff <= un_cnt_in;
         se_cnt_ff <= se_cnt_in;
         ts_cnt_ff <= ts_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_id_ff  <= head_id_in;
      head_cls_ff <= head_cls_in;
      status_ff   <= status_in;
      rm_id_ff    <= rm_id_in;
      rm_cls_ff   <= rm_cls_in;
   end

   // result beat
   assign rsp_status             = status_ff;
   assign rsp_removed_job_id     = rm_id_ff;
   assign rsp_removed_class      = rm_cls_ff;
   assign rsp_unclassified_count = un_cnt_ff;
   assign rsp_secret_count       = se_cnt_ff;
   assign rsp_top_secret_count   = ts_cnt_ff;
   assign rsp_head_class         = (occ_ff != '0) ? head_cls_ff : CLS_NONE;
   assign rsp_head_job_id        = (occ_ff != '0) ? head_id_ff : '0;

endmodule
